### src/fdtd_pkg.sv
// Package for the periodic Yee field stepper: codes, state and command types.
// Used by fdtd_ctrl, fdtd_dp, the top level and fdtd_chk; depends on nothing.
`default_nettype none

package fdtd_pkg;

  // item modes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // configuration register indexes
  localparam logic [2:0] REG_SIZE_X    = 3'd0;
  localparam logic [2:0] REG_SIZE_Y    = 3'd1;
  localparam logic [2:0] REG_SIZE_Z    = 3'd2;
  localparam logic [2:0] REG_COURANT_X = 3'd3;
  localparam logic [2:0] REG_COURANT_Y = 3'd4;
  localparam logic [2:0] REG_COURANT_Z = 3'd5;
  localparam logic [2:0] REG_GAIN      = 3'd6;

  // quantity code boundaries: E, then B, then J, three components each
  localparam logic [3:0] QTY_B_BASE = 4'd3;
  localparam logic [3:0] QTY_J_BASE = 4'd6;
  localparam logic [3:0] QTY_COUNT  = 4'd9;

  typedef enum logic [1:0] {
    FLD_E    = 2'd0,
    FLD_B    = 2'd1,
    FLD_J    = 2'd2,
    FLD_NONE = 2'd3
  } fld_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_LD_C,
    ST_LD_X,
    ST_LD_Y,
    ST_LD_Z,
    ST_LD_END,
    ST_CALC,
    ST_WRITE,
    ST_FINISH
  } state_e;

  // micro-steps of one component update
  typedef enum logic [2:0] {
    U_MUL_A,
    U_LOAD,
    U_MUL_B,
    U_SUB,
    U_CUR,
    U_RES
  } uop_e;

  typedef enum logic [2:0] {
    A_HOST,
    A_C,
    A_NX,
    A_NY,
    A_NZ
  } asel_e;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_OWN,
    CAP_NBX,
    CAP_NBY,
    CAP_NBZ
  } cap_e;

  typedef struct packed {
    asel_e      asel;
    logic       rd_en;
    cap_e       cap;
    logic       phase_b;
    uop_e       uop;
    logic [1:0] comp;
    logic       calc;
    logic       wr_step;
    logic       wr_host;
    logic       host_cap;
    logic       cnt_clr;
    logic       cnt_adv;
    logic       sat_clr;
    logic       ld_read;
    logic       ld_step;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### src/fdtd_ctrl.sv
// Sequencer of the field stepper: item handshake, cell walk and micro-steps.
// Depends on fdtd_pkg; drives fdtd_dp through cmd_t and reads sts_t.
`default_nettype none

module fdtd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     mode_i,
  input  fdtd_pkg::sts_t sts_i,
  output logic           in_stall_o,
  output fdtd_pkg::cmd_t cmd_o
);
  import fdtd_pkg::*;

  state_e     state_q, state_d;
  logic       phase_q, phase_d;
  logic [1:0] comp_q, comp_d;
  uop_e       uop_q, uop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      comp_q  <= 2'd0;
      uop_q   <= U_MUL_A;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      comp_q  <= comp_d;
      uop_q   <= uop_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    comp_d  = comp_q;
    uop_d   = uop_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && mode_i == MODE_READ) begin
          state_d = ST_RD_WAIT;
        end else if (in_valid_i && mode_i == MODE_STEP) begin
          state_d = ST_LD_C;
          phase_d = 1'b0;
        end
      end
      ST_RD_WAIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_LD_C:   state_d = ST_LD_X;
      ST_LD_X:   state_d = ST_LD_Y;
      ST_LD_Y:   state_d = ST_LD_Z;
      ST_LD_Z:   state_d = ST_LD_END;
      ST_LD_END: begin
        state_d = ST_CALC;
        comp_d  = 2'd0;
        uop_d   = U_MUL_A;
      end
      ST_CALC: begin
        if (uop_q == U_RES) begin
          uop_d = U_MUL_A;
          if (comp_q == 2'd2) state_d = ST_WRITE;
          else comp_d = comp_q + 2'd1;
        end else begin
          uop_d = uop_e'(uop_q + 3'd1);
        end
      end
      ST_WRITE: begin
        if (sts_i.last_cell) begin
          if (phase_q) begin
            state_d = ST_FINISH;
          end else begin
            phase_d = 1'b1;
            state_d = ST_LD_C;
          end
        end else begin
          state_d = ST_LD_C;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.asel    = A_HOST;
    cmd_o.cap     = CAP_NONE;
    cmd_o.phase_b = phase_q;
    cmd_o.uop     = uop_q;
    cmd_o.comp    = comp_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.host_cap = in_valid_i;
        cmd_o.wr_host  = in_valid_i && (mode_i == MODE_WRITE);
        cmd_o.cnt_clr  = in_valid_i && (mode_i == MODE_STEP);
        cmd_o.sat_clr  = in_valid_i && (mode_i == MODE_STEP);
      end
      ST_RD_WAIT: cmd_o.ld_read = sts_i.out_free;
      ST_LD_C: begin
        cmd_o.asel  = A_C;
        cmd_o.rd_en = 1'b1;
      end
      ST_LD_X: begin
        cmd_o.asel  = A_NX;
        cmd_o.rd_en = 1'b1;
        cmd_o.cap   = CAP_OWN;
      end
      ST_LD_Y: begin
        cmd_o.asel  = A_NY;
        cmd_o.rd_en = 1'b1;
        cmd_o.cap   = CAP_NBX;
      end
      ST_LD_Z: begin
        cmd_o.asel  = A_NZ;
        cmd_o.rd_en = 1'b1;
        cmd_o.cap   = CAP_NBY;
      end
      ST_LD_END: cmd_o.cap = CAP_NBZ;
      ST_CALC:   cmd_o.calc = 1'b1;
      ST_WRITE: begin
        cmd_o.wr_step = 1'b1;
        cmd_o.cnt_clr = sts_i.last_cell && !phase_q;
        cmd_o.cnt_adv = !sts_i.last_cell;
      end
      ST_FINISH: cmd_o.ld_step = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/fdtd_dp.sv
// Datapath of the field stepper: config registers, field memories, cell walk,
// shared multiplier, accumulate, round and saturate, output register.
// Depends on fdtd_pkg; controlled by fdtd_ctrl through cmd_t.
`default_nettype none

module fdtd_dp #(
  parameter int MAX_X = 16,
  parameter int MAX_Y = 16,
  parameter int MAX_Z = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [3:0]         cell_x_i,
  input  logic [3:0]         cell_y_i,
  input  logic [3:0]         cell_z_i,
  input  logic [3:0]         quantity_i,
  input  logic signed [31:0] value_in_i,
  input  logic               out_stall_i,
  input  fdtd_pkg::cmd_t     cmd_i,
  output fdtd_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  output logic signed [31:0] value_out_o,
  output logic               step_done_o,
  output logic               saturated_o
);
  import fdtd_pkg::*;

  localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int ZW    = $clog2(MAX_Z);

  // ---- configuration ----
  logic [4:0]  size_x_q, size_y_q, size_z_q;
  logic [23:0] cour_x_q, cour_y_q, cour_z_q;
  logic [31:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 5'd16;
      size_y_q <= 5'd16;
      size_z_q <= 5'd16;
      cour_x_q <= '0;
      cour_y_q <= '0;
      cour_z_q <= '0;
      gain_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SIZE_X:    size_x_q <= cfg_data_i[4:0];
        REG_SIZE_Y:    size_y_q <= cfg_data_i[4:0];
        REG_SIZE_Z:    size_z_q <= cfg_data_i[4:0];
        REG_COURANT_X: cour_x_q <= cfg_data_i[23:0];
        REG_COURANT_Y: cour_y_q <= cfg_data_i[23:0];
        REG_COURANT_Z: cour_z_q <= cfg_data_i[23:0];
        REG_GAIN:      gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // last index in use: size 0 acts as 1, oversize clamps to the store
  function automatic int last_idx(logic [4:0] s, int lim);
    int r;
    if (s == 5'd0) r = 0;
    else if (32'(s) > lim) r = lim - 1;
    else r = 32'(s) - 1;
    return r;
  endfunction

  logic [XW-1:0] lx;
  logic [YW-1:0] ly;
  logic [ZW-1:0] lz;
  assign lx = XW'(last_idx(size_x_q, MAX_X));
  assign ly = YW'(last_idx(size_y_q, MAX_Y));
  assign lz = ZW'(last_idx(size_z_q, MAX_Z));

  function automatic logic [AW-1:0] cell_addr(int unsigned x, int unsigned y, int unsigned z);
    return AW'((x * MAX_Y + y) * MAX_Z + z);
  endfunction

  // ---- cell walk ----
  logic [XW-1:0] i_q, ni;
  logic [YW-1:0] j_q, nj;
  logic [ZW-1:0] k_q, nk;
  logic          last_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cmd_i.cnt_adv) begin
      if (k_q == lz) begin
        k_q <= '0;
        if (j_q == ly) begin
          j_q <= '0;
          i_q <= i_q + XW'(1);
        end else begin
          j_q <= j_q + YW'(1);
        end
      end else begin
        k_q <= k_q + ZW'(1);
      end
    end
  end

  assign last_cell = (i_q == lx) && (j_q == ly) && (k_q == lz);

  // backward neighbors for the E pass, forward for the B pass, wrapped
  always_comb begin
    if (cmd_i.phase_b) begin
      ni = (i_q == lx) ? '0 : i_q + XW'(1);
      nj = (j_q == ly) ? '0 : j_q + YW'(1);
      nk = (k_q == lz) ? '0 : k_q + ZW'(1);
    end else begin
      ni = (i_q == '0) ? lx : i_q - XW'(1);
      nj = (j_q == '0) ? ly : j_q - YW'(1);
      nk = (k_q == '0) ? lz : k_q - ZW'(1);
    end
  end

  // ---- host access decode ----
  logic [AW-1:0] host_addr, addr_c, raddr, waddr;
  logic          host_ok;
  fld_e          hfld, hfld_q;
  logic [1:0]    hcomp, hcomp_q;

  assign host_addr = cell_addr(32'(cell_x_i), 32'(cell_y_i), 32'(cell_z_i));
  assign host_ok   = (32'(cell_x_i) < MAX_X) && (32'(cell_y_i) < MAX_Y) &&
                     (32'(cell_z_i) < MAX_Z) && (quantity_i < QTY_COUNT);
  assign addr_c    = cell_addr(32'(i_q), 32'(j_q), 32'(k_q));

  always_comb begin
    if (!host_ok) begin
      hfld  = FLD_NONE;
      hcomp = 2'd0;
    end else if (quantity_i < QTY_B_BASE) begin
      hfld  = FLD_E;
      hcomp = quantity_i[1:0];
    end else if (quantity_i < QTY_J_BASE) begin
      hfld  = FLD_B;
      hcomp = 2'(quantity_i - QTY_B_BASE);
    end else begin
      hfld  = FLD_J;
      hcomp = 2'(quantity_i - QTY_J_BASE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.host_cap) begin
      hfld_q  <= hfld;
      hcomp_q <= hcomp;
    end
  end

  always_comb begin
    case (cmd_i.asel)
      A_HOST:  raddr = host_addr;
      A_C:     raddr = addr_c;
      A_NX:    raddr = cell_addr(32'(ni), 32'(j_q), 32'(k_q));
      A_NY:    raddr = cell_addr(32'(i_q), 32'(nj), 32'(k_q));
      A_NZ:    raddr = cell_addr(32'(i_q), 32'(j_q), 32'(nk));
      default: raddr = host_addr;
    endcase
  end

  assign waddr = cmd_i.wr_step ? addr_c : host_addr;

  // ---- field memories: one per field component ----
  logic [31:0] e_rd [3];
  logic [31:0] b_rd [3];
  logic [31:0] j_rd [3];
  logic [31:0] new_t [3];

  for (genvar c = 0; c < 3; c++) begin : g_mem
    logic [31:0] e_mem [CELLS];
    logic [31:0] b_mem [CELLS];
    logic [31:0] j_mem [CELLS];
    logic        e_we, b_we, j_we;
    logic        host_hit;

    assign host_hit = cmd_i.wr_host && (hcomp == 2'(c));
    assign e_we = (cmd_i.wr_step && !cmd_i.phase_b) || (host_hit && hfld == FLD_E);
    assign b_we = (cmd_i.wr_step && cmd_i.phase_b) || (host_hit && hfld == FLD_B);
    assign j_we = host_hit && hfld == FLD_J;

    always_ff @(posedge clk_i) begin
      if (e_we) e_mem[waddr] <= cmd_i.wr_step ? new_t[c] : value_in_i;
      if (b_we) b_mem[waddr] <= cmd_i.wr_step ? new_t[c] : value_in_i;
      if (j_we) j_mem[waddr] <= value_in_i;
      if (cmd_i.rd_en) begin
        e_rd[c] <= e_mem[raddr];
        b_rd[c] <= b_mem[raddr];
        j_rd[c] <= j_mem[raddr];
      end
    end
  end

  // ---- operand capture ----
  logic [31:0] own [3];
  logic [31:0] tgt [3];
  logic [31:0] jv  [3];
  logic [31:0] nb  [3][3];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      case (cmd_i.cap)
        CAP_OWN: begin
          own[c] <= cmd_i.phase_b ? e_rd[c] : b_rd[c];
          tgt[c] <= cmd_i.phase_b ? b_rd[c] : e_rd[c];
          jv[c]  <= j_rd[c];
        end
        CAP_NBX: nb[0][c] <= cmd_i.phase_b ? e_rd[c] : b_rd[c];
        CAP_NBY: nb[1][c] <= cmd_i.phase_b ? e_rd[c] : b_rd[c];
        CAP_NBZ: nb[2][c] <= cmd_i.phase_b ? e_rd[c] : b_rd[c];
        default: ;
      endcase
    end
  end

  // ---- arithmetic ----
  function automatic logic signed [32:0] dif(logic [31:0] a, logic [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic logic signed [41:0] rnd24(logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd8388608;
    return $signed(t[65:24]);
  endfunction

  logic [1:0]         ax_a, cp_a, ax_b, cp_b;
  logic [23:0]        coef_a, coef_b;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_q, acc_q;
  logic signed [41:0] curl_q, cur;
  logic signed [43:0] sum;
  logic [31:0]        sat_val;
  logic               sat_hit, sat_q;

  // curl term of component q: coefA*dA - coefB*dB, d = own - neighbor
  always_comb begin
    case (cmd_i.comp)
      2'd0:    begin ax_a = 2'd1; cp_a = 2'd2; ax_b = 2'd2; cp_b = 2'd1; end
      2'd1:    begin ax_a = 2'd2; cp_a = 2'd0; ax_b = 2'd0; cp_b = 2'd2; end
      default: begin ax_a = 2'd0; cp_a = 2'd1; ax_b = 2'd1; cp_b = 2'd0; end
    endcase
  end

  always_comb begin
    case (ax_a)
      2'd0:    coef_a = cour_x_q;
      2'd1:    coef_a = cour_y_q;
      default: coef_a = cour_z_q;
    endcase
    case (ax_b)
      2'd0:    coef_b = cour_x_q;
      2'd1:    coef_b = cour_y_q;
      default: coef_b = cour_z_q;
    endcase
  end

  always_comb begin
    case (cmd_i.uop)
      U_MUL_A: begin
        ma = $signed({9'd0, coef_a});
        mb = dif(own[cp_a], nb[ax_a][cp_a]);
      end
      U_MUL_B: begin
        ma = $signed({9'd0, coef_b});
        mb = dif(own[cp_b], nb[ax_b][cp_b]);
      end
      U_CUR: begin
        ma = cmd_i.phase_b ? 33'sd0 : $signed({1'b0, gain_q});
        mb = $signed({jv[cmd_i.comp][31], jv[cmd_i.comp]});
      end
      default: begin
        ma = 33'sd0;
        mb = 33'sd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      case (cmd_i.uop)
        U_MUL_A, U_MUL_B: prod_q <= ma * mb;
        U_LOAD:           acc_q  <= prod_q;
        U_SUB:            acc_q  <= acc_q - prod_q;
        U_CUR: begin
          curl_q <= rnd24(acc_q);
          prod_q <= ma * mb;
        end
        U_RES:            new_t[cmd_i.comp] <= sat_val;
        default: ;
      endcase
    end
  end

  assign cur = rnd24(prod_q);
  assign sum = 44'(signed'(tgt[cmd_i.comp])) + 44'(curl_q) - 44'(cur);

  always_comb begin
    sat_hit = 1'b1;
    if (sum > 44'sd2147483647) sat_val = 32'h7fff_ffff;
    else if (sum < -44'sd2147483648) sat_val = 32'h8000_0000;
    else begin
      sat_val = sum[31:0];
      sat_hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sat_q <= 1'b0;
    else if (cmd_i.sat_clr) sat_q <= 1'b0;
    else if (cmd_i.calc && cmd_i.uop == U_RES && sat_hit) sat_q <= 1'b1;
  end

  // ---- output register ----
  logic [31:0] rd_val;
  logic        out_valid_q;

  always_comb begin
    case (hfld_q)
      FLD_E:   rd_val = e_rd[hcomp_q];
      FLD_B:   rd_val = b_rd[hcomp_q];
      FLD_J:   rd_val = j_rd[hcomp_q];
      default: rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.ld_read || cmd_i.ld_step) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_read) begin
      value_out_o <= rd_val;
      step_done_o <= 1'b0;
      saturated_o <= 1'b0;
    end else if (cmd_i.ld_step) begin
      value_out_o <= '0;
      step_done_o <= 1'b1;
      saturated_o <= sat_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.last_cell = last_cell;

endmodule

`default_nettype wire

### src/fdtd_yee_periodic_step.sv
// Top level of the periodic 3D Yee field stepper (E, B, J on a cell grid).
// Depends on fdtd_pkg, fdtd_ctrl (sequencer) and fdtd_dp (datapath).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   cfg     | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_stall_o | mode_i, cell_x/y/z_i, quantity_i,
//           |           |                        | value_in_i
//   out     | out       | out_valid_o/out_stall_i | value_out_o, step_done_o, saturated_o
//
// A write transfer makes no result. A read passes through the registered
// memory read, then the output register.
// A step walks every cell in use twice, E pass then B pass; each cell per
// pass takes 4 memory reads, 3 components of 6 multiply/accumulate steps on
// the one shared multiplier, and 1 write.
// Reset clears control and configuration; field memories hold garbage until
// written. A result waits in the output register while out_stall_i is high;
// writes are still taken then, reads and steps hold at their last cycle.
`default_nettype none

module fdtd_yee_periodic_step #(
  parameter int MAX_X = 16,
  parameter int MAX_Y = 16,
  parameter int MAX_Z = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         cell_x_i,
  input  logic [3:0]         cell_y_i,
  input  logic [3:0]         cell_z_i,
  input  logic [3:0]         quantity_i,
  input  logic signed [31:0] value_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_out_o,
  output logic               step_done_o,
  output logic               saturated_o
);
  import fdtd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts items and steps the datapath through each cell
  fdtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // datapath: memories, curl arithmetic and the output register
  fdtd_dp #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .quantity_i  (quantity_i),
    .value_in_i  (value_in_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .value_out_o (value_out_o),
    .step_done_o (step_done_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire

### src/fdtd_chk.sv
// Port-level checker for the field stepper, bound to the top level.
// Depends on fdtd_pkg and the ports of fdtd_yee_periodic_step.
`default_nettype none

module fdtd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         mode_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] value_out_o,
  input logic               step_done_o,
  input logic               saturated_o
);
  import fdtd_pkg::*;

  // reads and steps occupy the block after their transfer
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_READ || mode_i == MODE_STEP)
    |=> in_stall_o)
    else $error("read or step transfer did not hold off the input");

  // a write makes no result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_WRITE && !out_valid_o
    |=> !out_valid_o)
    else $error("write transfer produced a result");

  // a step result carries zero data
  a_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_done_o |-> value_out_o == 32'sd0)
    else $error("step result with nonzero value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> out_valid_o && $stable(value_out_o) && $stable(step_done_o) &&
        $stable(saturated_o))
    else $error("stalled result changed");

endmodule

bind fdtd_yee_periodic_step fdtd_chk u_chk (.*);

`default_nettype wire
